FILE: rtl/lzbr_pkg.sv
// Package with the shared types and constants of the LZ bitstream recoder.
package lzbr_pkg;

  localparam int LZBR_INDEX_BITS = 16;
  localparam int LZBR_MAX_RES    = 16;
  localparam int LZBR_RES_BITS   = $clog2(LZBR_MAX_RES);
  localparam int LZBR_GAMMA_BITS = 17;

  typedef enum logic [3:0] {
    PH_LIT_CTL    = 4'd0,
    PH_LIT_DATA   = 4'd1,
    PH_LIT_BYTES  = 4'd2,
    PH_AFTER_LIT  = 4'd3,
    PH_REP_CTL    = 4'd4,
    PH_REP_DATA   = 4'd5,
    PH_AFTER_COPY = 4'd6,
    PH_OFF_CTL    = 4'd7,
    PH_OFF_DATA   = 4'd8,
    PH_OFF_LOW    = 4'd9,
    PH_LEN_CTL    = 4'd10,
    PH_LEN_DATA   = 4'd11,
    PH_DONE       = 4'd12,
    PH_LONG       = 4'd13,
    PH_TRUNC      = 4'd14
  } phase_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BITS,
    S_PRE,
    S_NORM,
    S_GZ,
    S_GD,
    S_GEND,
    S_EFL,
    S_FIN,
    S_OUT
  } seq_t;

  typedef enum logic [1:0] {
    ST_RUN   = 2'd0,
    ST_DONE  = 2'd1,
    ST_LONG  = 2'd2,
    ST_TRUNC = 2'd3
  } status_t;

  typedef struct packed {
    logic        en;
    logic [15:0] idx;
    logic [7:0]  data;
  } push_t;

  typedef struct packed {
    logic [15:0] idx;
    logic [7:0]  data;
  } entry_t;

endpackage

FILE: rtl/lzbr_if.sv
// Channel interfaces for the input bytes and the result writes.
interface lzbr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] packed_byte;
  logic       final_byte;
  modport source (output valid, output packed_byte, output final_byte, input ready);
  modport sink (input valid, input packed_byte, input final_byte, output ready);
endinterface

interface lzbr_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] write_index;
  logic [7:0]  write_data;
  logic        write_valid;
  logic [1:0]  stream_status;
  logic        last_of_run;
  modport source (output valid, output write_index, output write_data, output write_valid,
                  output stream_status, output last_of_run, input ready);
  modport sink (input valid, input write_index, input write_data, input write_valid,
                input stream_status, input last_of_run, output ready);
endinterface

FILE: rtl/lzbr_wbuf.sv
// Buffer that collects the byte writes of one item until they are delivered.
module lzbr_wbuf (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            clr,
  input  lzbr_pkg::push_t                 push,
  input  logic [lzbr_pkg::LZBR_RES_BITS-1:0] rd_addr,
  output logic [lzbr_pkg::LZBR_RES_BITS:0]   cnt,
  output lzbr_pkg::entry_t                rd_entry
);
  import lzbr_pkg::*;

  entry_t                 mem [LZBR_MAX_RES];
  logic [LZBR_RES_BITS:0] base;
  logic                   full;

  assign base = clr ? '0 : cnt;
  assign full = (base == (LZBR_RES_BITS+1)'(LZBR_MAX_RES));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (push.en && !full) begin
      cnt <= base + 1'b1;
    end else begin
      cnt <= base;
    end
  end

  always_ff @(posedge clk) begin
    if (push.en && !full) begin
      mem[base[LZBR_RES_BITS-1:0]] <= '{idx: push.idx, data: push.data};
    end
  end

  always_ff @(posedge clk) begin
    if (push.en && !full && base[LZBR_RES_BITS-1:0] == rd_addr) begin
      rd_entry <= '{idx: push.idx, data: push.data};
    end else begin
      rd_entry <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/lz_bitstream_recoder_top.sv
// Top level of the LZ bitstream recoder.
// The block takes a compressed stream one byte per item on in_ch and rewrites
// it into the second bit layout. Each input item yields one or more result
// items on out_ch; each carries an indexed byte write or, when the input wrote
// nothing, an empty result with write_valid low. Every result carries the
// stream status after its input, and last_of_run marks the final result.
// A small sequencer walks the control bits of the byte one per cycle while
// no code is being re-emitted and drives a single bit-group packer; each
// re-emitted gamma code first runs through an iterative leading-one search
// and then sends two bits per code digit, one per cycle.
// The writes of an item are held in a 16-entry buffer and delivered after the
// item is fully parsed, so in_ch is not ready while results are pending.
// When out_ch stalls, the current result holds until it is taken. Synchronous
// reset returns the parser to stream start, end marker omitted; the user
// writes that option via cfg_wr_en only while the block is idle (unenforced).
module lz_bitstream_recoder_top #(
  parameter int INDEX_BITS = lzbr_pkg::LZBR_INDEX_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  lzbr_in_if.sink           in_ch,
  lzbr_out_if.source        out_ch
);
  import lzbr_pkg::*;

  localparam int GB = LZBR_GAMMA_BITS;
  localparam int NB = $clog2(GB);

  seq_t   st, st_next;
  phase_t phase, phase_next;
  logic   omit;
  logic   fin;
  logic [7:0]            ib_buf, ib_buf_next;
  logic [3:0]            ib_left, ib_left_next;
  logic [GB-1:0]         gacc, gacc_next;
  logic [15:0]           lit_left, lit_left_next;
  logic [INDEX_BITS-1:0] out_pos, out_pos_next;
  logic [INDEX_BITS-1:0] grp_pos, grp_pos_next;
  logic [7:0]            grp_bits, grp_bits_next;
  logic [7:0]            grp_mask, grp_mask_next;
  logic                  first_tok, first_tok_next;
  logic                  pre_en, pre_en_next, pre_bit, pre_bit_next;
  logic                  gam_en, gam_en_next, end_flush, end_flush_next;
  logic                  skip, skip_next;
  logic [GB-1:0]         gam_val, gam_val_next;
  logic [GB-1:0]         nsh, nsh_next;
  logic [NB-1:0]         nbits, nbits_next;
  logic [NB-1:0]         gi, gi_next;
  logic [GB-1:0]         gv, gv_next;
  logic [LZBR_RES_BITS-1:0] rd, rd_next;

  logic          in_acc, out_acc, bit_phase, bit_go, job_start, out_last;
  logic          cur_bit, em_en, em_bit, fl_en, put_en;
  logic [7:0]    put_data;
  push_t         push;
  logic          buf_clr;
  logic [LZBR_RES_BITS:0] cnt;
  entry_t        rd_entry;
  logic [GB-1:0] gm1, vmask, vswz;
  logic [7:0]    m, gbits;

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign out_acc   = out_ch.valid && out_ch.ready;
  assign bit_phase = (phase <= PH_LEN_DATA) && (phase != PH_LIT_BYTES) &&
                     (phase != PH_OFF_LOW);
  assign bit_go    = (ib_left != 4'd0) && bit_phase;
  assign cur_bit   = ib_buf[7];
  assign out_last  = (cnt == '0) || ({1'b0, rd} == cnt - 1'b1);
  assign buf_clr   = (st == S_IDLE) && in_acc;
  assign gm1       = gacc - 1'b1;
  assign vmask     = gam_val & ((GB'(1) << nbits) - 1'b1);
  assign vswz      = (nbits >= NB'(8)) ?
                     ((vmask >> 8) | ((vmask & GB'(8'hff)) << (nbits - NB'(8)))) : gam_val;

  always_comb begin
    st_next = st;
    case (st)
      S_IDLE: if (in_acc) st_next = (phase > PH_LEN_DATA) ? S_OUT : S_BITS;
      S_BITS: st_next = bit_go ? (job_start ? S_PRE : S_BITS) : S_FIN;
      S_PRE:  st_next = gam_en ? S_NORM : S_GEND;
      S_NORM: begin
        if (nsh[GB-1] || nbits == '0) st_next = (nbits == '0) ? S_GEND : S_GZ;
      end
      S_GZ:   st_next = S_GD;
      S_GD:   st_next = (gi == '0) ? S_GEND : S_GZ;
      S_GEND: st_next = end_flush ? S_EFL : S_BITS;
      S_EFL:  st_next = S_BITS;
      S_FIN:  st_next = S_OUT;
      S_OUT:  if (out_acc && out_last) st_next = S_IDLE;
      default: st_next = S_IDLE;
    endcase
  end

  always_comb begin
    phase_next     = phase;
    ib_buf_next    = ib_buf;
    ib_left_next   = ib_left;
    gacc_next      = gacc;
    lit_left_next  = lit_left;
    out_pos_next   = out_pos;
    grp_pos_next   = grp_pos;
    grp_bits_next  = grp_bits;
    grp_mask_next  = grp_mask;
    first_tok_next = first_tok;
    pre_en_next    = pre_en;
    pre_bit_next   = pre_bit;
    gam_en_next    = gam_en;
    end_flush_next = end_flush;
    skip_next      = skip;
    gam_val_next   = gam_val;
    nsh_next       = nsh;
    nbits_next     = nbits;
    gi_next        = gi;
    gv_next        = gv;
    rd_next        = rd;
    job_start      = 1'b0;
    em_en          = 1'b0;
    em_bit         = 1'b0;
    fl_en          = 1'b0;
    put_en         = 1'b0;
    put_data       = in_ch.packed_byte;
    push           = '{en: 1'b0, idx: '0, data: '0};
    m              = '0;
    gbits          = '0;

    case (st)
      S_IDLE: begin
        rd_next = '0;
        if (in_acc && phase <= PH_LEN_DATA) begin
          if (phase == PH_LIT_BYTES) begin
            put_en = 1'b1;
            if (lit_left == 16'd0) phase_next = PH_AFTER_LIT;
            else lit_left_next = lit_left - 1'b1;
          end else if (phase == PH_OFF_LOW) begin
            put_en   = 1'b1;
            put_data = {~in_ch.packed_byte[7:1], in_ch.packed_byte[0]};
            if (in_ch.packed_byte[0]) begin
              phase_next = PH_AFTER_COPY;
            end else begin
              gacc_next  = GB'(1);
              phase_next = PH_LEN_DATA;
            end
          end else begin
            ib_buf_next  = in_ch.packed_byte;
            ib_left_next = 4'd8;
          end
        end
      end
      S_BITS: begin
        if (bit_go) begin
          ib_buf_next    = {ib_buf[6:0], 1'b0};
          ib_left_next   = ib_left - 1'b1;
          pre_en_next    = 1'b0;
          pre_bit_next   = 1'b0;
          gam_en_next    = 1'b1;
          end_flush_next = 1'b0;
          skip_next      = 1'b0;
          gam_val_next   = gacc;
          case (phase)
            PH_LIT_CTL: begin
              if (cur_bit) begin
                job_start      = 1'b1;
                pre_en_next    = !first_tok;
                first_tok_next = 1'b0;
                lit_left_next  = gm1[GB-1] ? 16'hffff : gm1[15:0];
                phase_next     = PH_LIT_BYTES;
              end else begin
                phase_next = PH_LIT_DATA;
              end
            end
            PH_AFTER_LIT: begin
              gacc_next  = GB'(1);
              phase_next = cur_bit ? PH_OFF_CTL : PH_REP_CTL;
            end
            PH_REP_CTL: begin
              if (cur_bit) begin
                job_start   = 1'b1;
                pre_en_next = 1'b1;
                phase_next  = PH_AFTER_COPY;
              end else begin
                phase_next = PH_REP_DATA;
              end
            end
            PH_AFTER_COPY: begin
              gacc_next  = GB'(1);
              phase_next = cur_bit ? PH_OFF_CTL : PH_LIT_CTL;
            end
            PH_OFF_CTL: begin
              if (cur_bit) begin
                job_start    = 1'b1;
                pre_en_next  = 1'b1;
                pre_bit_next = 1'b1;
                if (gacc == GB'(256)) begin
                  pre_en_next    = !omit;
                  gam_en_next    = !omit;
                  end_flush_next = 1'b1;
                  phase_next     = fin ? PH_DONE : PH_LONG;
                end else begin
                  phase_next = PH_OFF_LOW;
                end
              end else begin
                phase_next = PH_OFF_DATA;
              end
            end
            PH_LEN_CTL: begin
              if (cur_bit) begin
                job_start  = 1'b1;
                skip_next  = 1'b1;
                phase_next = PH_AFTER_COPY;
              end else begin
                phase_next = PH_LEN_DATA;
              end
            end
            PH_LIT_DATA, PH_REP_DATA, PH_OFF_DATA, PH_LEN_DATA: begin
              if (gacc[GB-1]) gacc_next = '1;
              else gacc_next = {gacc[GB-2:0], cur_bit ^ (phase == PH_OFF_DATA)};
              case (phase)
                PH_LIT_DATA: phase_next = PH_LIT_CTL;
                PH_REP_DATA: phase_next = PH_REP_CTL;
                PH_OFF_DATA: phase_next = PH_OFF_CTL;
                default:     phase_next = PH_LEN_CTL;
              endcase
            end
            default: phase_next = phase;
          endcase
        end
      end
      S_PRE: begin
        em_en      = pre_en;
        em_bit     = pre_bit;
        nsh_next   = gam_val;
        nbits_next = NB'(GB-1);
      end
      S_NORM: begin
        if (nsh[GB-1] || nbits == '0) begin
          gv_next = vswz;
          gi_next = nbits - 1'b1;
        end else begin
          nsh_next   = {nsh[GB-2:0], 1'b0};
          nbits_next = nbits - 1'b1;
        end
      end
      S_GZ: begin
        em_en     = !skip;
        em_bit    = 1'b0;
        skip_next = 1'b0;
      end
      S_GD: begin
        em_en  = 1'b1;
        em_bit = gv[gi];
        if (gi != '0) gi_next = gi - 1'b1;
      end
      S_GEND: begin
        em_en  = gam_en && !skip;
        em_bit = 1'b1;
      end
      S_EFL: fl_en = 1'b1;
      S_FIN: begin
        if (fin && phase <= PH_LEN_DATA) begin
          fl_en      = 1'b1;
          phase_next = PH_TRUNC;
        end
      end
      S_OUT: begin
        if (out_acc && !out_last) rd_next = rd + 1'b1;
      end
      default: ;
    endcase

    if (put_en) begin
      push         = '{en: 1'b1, idx: 16'(out_pos), data: put_data};
      out_pos_next = out_pos + 1'b1;
    end
    if (em_en) begin
      m     = grp_mask;
      gbits = grp_bits;
      if (grp_mask == 8'd0) begin
        m            = 8'h80;
        gbits        = 8'd0;
        grp_pos_next = out_pos;
        out_pos_next = out_pos + 1'b1;
      end
      if (em_bit) gbits = gbits | m;
      m             = m >> 1;
      grp_bits_next = gbits;
      grp_mask_next = m;
      if (m == 8'd0) begin
        push = '{en: 1'b1, idx: 16'(grp_pos_next), data: gbits};
      end
    end
    if (fl_en && grp_mask != 8'd0) begin
      push          = '{en: 1'b1, idx: 16'(grp_pos), data: grp_bits};
      grp_mask_next = 8'd0;
    end
  end

  always_comb begin
    in_ch.ready          = (st == S_IDLE);
    out_ch.valid         = (st == S_OUT);
    out_ch.write_valid   = (cnt != '0);
    out_ch.write_index   = (cnt != '0) ? rd_entry.idx : 16'd0;
    out_ch.write_data    = (cnt != '0) ? rd_entry.data : 8'd0;
    out_ch.last_of_run   = out_last;
    case (phase)
      PH_DONE:  out_ch.stream_status = ST_DONE;
      PH_LONG:  out_ch.stream_status = ST_LONG;
      PH_TRUNC: out_ch.stream_status = ST_TRUNC;
      default:  out_ch.stream_status = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      phase     <= PH_LIT_CTL;
      omit      <= 1'b1;
      ib_left   <= '0;
      gacc      <= GB'(1);
      lit_left  <= '0;
      out_pos   <= '0;
      grp_pos   <= '0;
      grp_mask  <= '0;
      first_tok <= 1'b1;
      rd        <= '0;
    end else begin
      st        <= st_next;
      phase     <= phase_next;
      if (cfg_wr_en) omit <= cfg_wr_data;
      ib_left   <= ib_left_next;
      gacc      <= gacc_next;
      lit_left  <= lit_left_next;
      out_pos   <= out_pos_next;
      grp_pos   <= grp_pos_next;
      grp_mask  <= grp_mask_next;
      first_tok <= first_tok_next;
      rd        <= rd_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) fin <= in_ch.final_byte;
    ib_buf    <= ib_buf_next;
    grp_bits  <= grp_bits_next;
    pre_en    <= pre_en_next;
    pre_bit   <= pre_bit_next;
    gam_en    <= gam_en_next;
    end_flush <= end_flush_next;
    skip      <= skip_next;
    gam_val   <= gam_val_next;
    nsh       <= nsh_next;
    nbits     <= nbits_next;
    gi        <= gi_next;
    gv        <= gv_next;
  end

  lzbr_wbuf u_wbuf (
    .clk      (clk),
    .rst      (rst),
    .clr      (buf_clr),
    .push     (push),
    .rd_addr  (rd_next),
    .cnt      (cnt),
    .rd_entry (rd_entry)
  );

endmodule

FILE: rtl/lzbr_checker.sv
// Port checker for the LZ bitstream recoder and its bind to the top level.
module lzbr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] write_index,
  input logic [7:0]  write_data,
  input logic        write_valid,
  input logic        last_of_run
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(write_index) && $stable(write_data))
    else $error("Stalled result changed.");

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("Input ready while results are pending.");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !write_valid |-> last_of_run && write_index == 16'd0 && write_data == 8'd0)
    else $error("Empty result is not a lone last result.");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Result shown right after reset.");

endmodule

bind lz_bitstream_recoder_top lzbr_checker u_lzbr_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .write_index (out_ch.write_index),
  .write_data  (out_ch.write_data),
  .write_valid (out_ch.write_valid),
  .last_of_run (out_ch.last_of_run)
);
